FILE: sv/pac_pkg.sv
// Shared types and constants for the pigment adsorption cell.
package pac_pkg;

	localparam int unsigned DataW = 16;
	localparam int unsigned CfgIdxW = 3;
	localparam int unsigned Latency = 5;

	localparam logic [16:0] ONE_Q16 = 17'h10000;
	localparam logic [15:0] ONE_Q15 = 16'h8000;
	localparam logic [15:0] MAX_OUT = 16'hFFFF;

	localparam logic [CfgIdxW-1:0] CFG_GRAN_A = 3'd0;
	localparam logic [CfgIdxW-1:0] CFG_DENS_A = 3'd1;
	localparam logic [CfgIdxW-1:0] CFG_INVST_A = 3'd2;
	localparam logic [CfgIdxW-1:0] CFG_GRAN_B = 3'd3;
	localparam logic [CfgIdxW-1:0] CFG_DENS_B = 3'd4;
	localparam logic [CfgIdxW-1:0] CFG_INVST_B = 3'd5;

	localparam logic [DataW-1:0] RST_GRAN_A = 16'd53084;
	localparam logic [DataW-1:0] RST_DENS_A = 16'd1311;
	localparam logic [DataW-1:0] RST_INVST_A = 16'd11916;
	localparam logic [DataW-1:0] RST_GRAN_B = 16'd59638;
	localparam logic [DataW-1:0] RST_DENS_B = 16'd655;
	localparam logic [DataW-1:0] RST_INVST_B = 16'd21141;

	typedef struct packed {
		logic [DataW-1:0] gran;
		logic [DataW-1:0] dens;
		logic [DataW-1:0] inv_st;
	} pac_pigment_t;

	typedef struct packed {
		logic             vld;
		logic             wet;
		logic [DataW-1:0] g;
		logic [DataW-1:0] d;
		logic [DataW-1:0] down;
		logic [DataW-1:0] up;
	} pac_xfer_t;

endpackage

FILE: sv/pac_cfg_regs.sv
// Per-pigment configuration registers.
module pac_cfg_regs import pac_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [CfgIdxW-1:0] cfg_index,
	input  logic [DataW-1:0]   cfg_wdata,
	output pac_pigment_t       pig_a,
	output pac_pigment_t       pig_b
);

	pac_pigment_t pig_a_q, pig_b_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pig_a_q <= '{gran: RST_GRAN_A, dens: RST_DENS_A, inv_st: RST_INVST_A};
			pig_b_q <= '{gran: RST_GRAN_B, dens: RST_DENS_B, inv_st: RST_INVST_B};
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_GRAN_A:  pig_a_q.gran <= cfg_wdata;
				CFG_DENS_A:  pig_a_q.dens <= cfg_wdata;
				CFG_INVST_A: pig_a_q.inv_st <= cfg_wdata;
				CFG_GRAN_B:  pig_b_q.gran <= cfg_wdata;
				CFG_DENS_B:  pig_b_q.dens <= cfg_wdata;
				CFG_INVST_B: pig_b_q.inv_st <= cfg_wdata;
				default: ;
			endcase
		end
	end

	assign pig_a = pig_a_q;
	assign pig_b = pig_b_q;

endmodule

FILE: sv/pac_mul_pipe.sv
// Four-stage multiplier pipeline producing the raw deposit and lift amounts.
module pac_mul_pipe import pac_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_vld,
	input  logic [DataW-1:0] g_in,
	input  logic [DataW-1:0] d_in,
	input  logic [DataW-1:0] h_in,
	input  logic             wet_in,
	input  logic             sel_in,
	input  pac_pigment_t     pig_a,
	input  pac_pigment_t     pig_b,
	output pac_xfer_t        xfer
);

	pac_pigment_t pig;
	logic [31:0] hg_prod, hug_prod;
	logic [16:0] h_inv;
	logic [16:0] fdn, fup;

	logic             vld_s1, vld_s2, vld_s3, vld_s4;
	logic             wet_s1, wet_s2, wet_s3, wet_s4;
	logic [DataW-1:0] g_s1, g_s2, g_s3, g_s4;
	logic [DataW-1:0] d_s1, d_s2, d_s3, d_s4;
	logic [16:0]      fdn_s1, fup_s1;
	logic [DataW-1:0] dens_s1, dens_s2;
	logic [DataW-1:0] inv_s1, inv_s2, inv_s3;
	logic [DataW-1:0] a1_s2, b1_s2, b2_s3, down_s3, down_s4, up_s4;

	logic [32:0] a1_prod, b1_prod;
	logic [31:0] down_prod, b2_prod, up_prod;

	// stage 1: height factors
	always_comb begin
		pig = sel_in ? pig_b : pig_a;
		h_inv = ONE_Q16 - {1'b0, h_in};
		hg_prod = 32'(h_in) * 32'(pig.gran);
		hug_prod = 32'(h_inv) * 32'(pig.gran);
		fdn = ONE_Q16 - {1'b0, hg_prod[31:16]};
		fup = ONE_Q16 - {1'b0, hug_prod[31:16]};
	end

	assign a1_prod = 33'(g_s1) * 33'(fdn_s1);
	assign b1_prod = 33'(d_s1) * 33'(fup_s1);
	assign down_prod = 32'(a1_s2) * 32'(dens_s2);
	assign b2_prod = 32'(b1_s2) * 32'(dens_s2);
	assign up_prod = 32'(b2_s3) * 32'(inv_s3);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else begin
			vld_s1 <= in_vld;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		wet_s1  <= wet_in;
		g_s1    <= g_in;
		d_s1    <= d_in;
		fdn_s1  <= fdn;
		fup_s1  <= fup;
		dens_s1 <= pig.dens;
		inv_s1  <= pig.inv_st;

		wet_s2  <= wet_s1;
		g_s2    <= g_s1;
		d_s2    <= d_s1;
		a1_s2   <= a1_prod[31:16];
		b1_s2   <= b1_prod[31:16];
		dens_s2 <= dens_s1;
		inv_s2  <= inv_s1;

		wet_s3  <= wet_s2;
		g_s3    <= g_s2;
		d_s3    <= d_s2;
		down_s3 <= down_prod[31:16];
		b2_s3   <= b2_prod[31:16];
		inv_s3  <= inv_s2;

		wet_s4  <= wet_s3;
		g_s4    <= g_s3;
		d_s4    <= d_s3;
		down_s4 <= down_s3;
		up_s4   <= up_prod[31:16];
	end

	assign xfer = '{vld: vld_s4, wet: wet_s4, g: g_s4, d: d_s4, down: down_s4, up: up_s4};

endmodule

FILE: sv/pac_settle.sv
// Clamp the amounts, apply the transfer and saturate for wet cells; register the result beat.
module pac_settle import pac_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  pac_xfer_t        xfer,
	output logic             done,
	output logic [DataW-1:0] new_suspended,
	output logic [DataW-1:0] new_deposited
);

	logic [16:0]      dsum, gsum;
	logic [DataW-1:0] down_c, up_c;
	logic [17:0]      ng, nd;
	logic [DataW-1:0] ng_sat, nd_sat;
	logic             done_q;
	logic [DataW-1:0] ns_q, nd_q;

	always_comb begin
		dsum = {1'b0, xfer.d} + {1'b0, xfer.down};
		gsum = {1'b0, xfer.g} + {1'b0, xfer.up};
		down_c = xfer.down;
		up_c = xfer.up;
		if (dsum > {1'b0, ONE_Q15})
			down_c = (xfer.d < ONE_Q15) ? (ONE_Q15 - xfer.d) : '0;
		if (gsum > {1'b0, ONE_Q15})
			up_c = (xfer.g < ONE_Q15) ? (ONE_Q15 - xfer.g) : '0;
		ng = {2'b00, xfer.g} - {2'b00, down_c} + {2'b00, up_c};
		nd = {2'b00, xfer.d} + {2'b00, down_c} - {2'b00, up_c};
		if (ng[17])      ng_sat = '0;
		else if (ng[16]) ng_sat = MAX_OUT;
		else             ng_sat = ng[15:0];
		if (nd[17])      nd_sat = '0;
		else if (nd[16]) nd_sat = MAX_OUT;
		else             nd_sat = nd[15:0];
		if (!xfer.wet) begin
			ng_sat = xfer.g;
			nd_sat = xfer.d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) done_q <= 1'b0;
		else         done_q <= xfer.vld;
	end

	always_ff @(posedge clk) begin
		ns_q <= ng_sat;
		nd_q <= nd_sat;
	end

	assign done = done_q;
	assign new_suspended = ns_q;
	assign new_deposited = nd_q;

endmodule

FILE: sv/pigment_adsorption_cell.sv
// Top level of the pigment adsorption cell.
// Takes one cell per clock whenever start is high; busy never rises. Each cell's result
// appears on new_suspended/new_deposited with a one-cycle done strobe after it has passed
// through the four multiplier stages (height factors, layer scaling, density, staining)
// and the clamp/saturate output register. The receiver cannot stall the beat.
// Configuration writes land on the next edge and must be made while no cell is in flight.
module pigment_adsorption_cell import pac_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [DataW-1:0]   suspended,
	input  logic [DataW-1:0]   deposited,
	input  logic [DataW-1:0]   paper_height,
	input  logic               wet,
	input  logic               pigment_sel,
	input  logic               cfg_we,
	input  logic [CfgIdxW-1:0] cfg_index,
	input  logic [DataW-1:0]   cfg_wdata,
	output logic               done,
	output logic [DataW-1:0]   new_suspended,
	output logic [DataW-1:0]   new_deposited
);

	pac_pigment_t pig_a, pig_b;
	pac_xfer_t    xfer;

	assign busy = 1'b0;

	pac_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.pig_a     (pig_a),
		.pig_b     (pig_b)
	);

	pac_mul_pipe u_pipe (
		.clk    (clk),
		.arst_n (arst_n),
		.in_vld (start & ~busy),
		.g_in   (suspended),
		.d_in   (deposited),
		.h_in   (paper_height),
		.wet_in (wet),
		.sel_in (pigment_sel),
		.pig_a  (pig_a),
		.pig_b  (pig_b),
		.xfer   (xfer)
	);

	pac_settle u_settle (
		.clk           (clk),
		.arst_n        (arst_n),
		.xfer          (xfer),
		.done          (done),
		.new_suspended (new_suspended),
		.new_deposited (new_deposited)
	);

endmodule

FILE: sv/pac_checker.sv
// Port-level checks for the pigment adsorption cell, bound to the top level.
module pac_checker import pac_pkg::*; (
	input logic             clk,
	input logic             arst_n,
	input logic             start,
	input logic             busy,
	input logic [DataW-1:0] suspended,
	input logic [DataW-1:0] deposited,
	input logic             wet,
	input logic             done,
	input logic [DataW-1:0] new_suspended,
	input logic [DataW-1:0] new_deposited
);

	a_beat_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##5 done)
		else $error("accepted cell did not produce a result beat");

	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		!(start && !busy) |-> ##5 !done)
		else $error("result beat without an accepted cell");

	a_dry_pass: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && !wet) |-> ##5
		(new_suspended == $past(suspended, 5)) && (new_deposited == $past(deposited, 5)))
		else $error("dry cell altered");

	a_conserve: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##5
		(({1'b0, new_suspended} + {1'b0, new_deposited}) ==
		 ({1'b0, $past(suspended, 5)} + {1'b0, $past(deposited, 5)})))
		else $error("pigment not conserved");

endmodule

bind pigment_adsorption_cell pac_checker u_pac_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.start         (start),
	.busy          (busy),
	.suspended     (suspended),
	.deposited     (deposited),
	.wet           (wet),
	.done          (done),
	.new_suspended (new_suspended),
	.new_deposited (new_deposited)
);
